// ===== src/ppdw_pkg.sv =====
package ppdw_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned RegW   = 31;
    localparam int unsigned MagW   = 32;
    localparam int unsigned SqW    = 64;
    localparam int unsigned SumW   = 66;
    localparam int unsigned RootW  = 32;
    localparam int unsigned RemW   = 34;
    localparam int unsigned NumW   = 47;
    localparam int unsigned DremW  = 33;
    localparam int unsigned IdxW   = 3;

    localparam logic [IdxW-1:0] CFG_BOX_X  = 3'd0;
    localparam logic [IdxW-1:0] CFG_BOX_Y  = 3'd1;
    localparam logic [IdxW-1:0] CFG_BOX_Z  = 3'd2;
    localparam logic [IdxW-1:0] CFG_CUTOFF = 3'd3;

    localparam logic [RegW-1:0] BOX_RESET    = 31'd65536;
    localparam logic [RegW-1:0] CUTOFF_RESET = 31'd131072;
    localparam logic [NumW-1:0] Q_ONE        = 47'd65536;
    localparam logic [31:0]     SAT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [CoordW-1:0] self_x;
        logic signed [CoordW-1:0] self_y;
        logic signed [CoordW-1:0] self_z;
        logic signed [CoordW-1:0] other_x;
        logic signed [CoordW-1:0] other_y;
        logic signed [CoordW-1:0] other_z;
    } t_in_item;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] weight;
        logic        saturated;
    } t_out_item;

    typedef struct packed {
        logic [RegW-1:0] box_x;
        logic [RegW-1:0] box_y;
        logic [RegW-1:0] box_z;
    } t_box_cfg;

    function automatic logic [MagW-1:0] axis_mag(
        input logic signed [CoordW-1:0] self_c,
        input logic signed [CoordW-1:0] other_c,
        input logic [RegW-1:0]          len
    );
        logic signed [33:0] d;
        logic signed [33:0] twod;
        logic signed [33:0] l;
        logic signed [33:0] w;
        d    = 34'(other_c) - 34'(self_c);
        twod = d <<< 1;
        l    = $signed({3'b000, len});
        if (twod < -l) begin
            w = d + l;
        end else if (twod > l) begin
            w = d - l;
        end else begin
            w = d;
        end
        if (w < 0) begin
            w = -w;
        end
        return w[MagW-1:0];
    endfunction

endpackage

// ===== src/ppdw_if.sv =====
interface ppdw_in_if;
    logic                 valid;
    logic                 ready;
    ppdw_pkg::t_in_item   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ppdw_out_if;
    logic                 valid;
    logic                 ready;
    ppdw_pkg::t_out_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== src/ppdw_front.sv =====
module ppdw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  ppdw_pkg::t_in_item             i_item,
    input  ppdw_pkg::t_box_cfg             i_box,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ppdw_pkg::SumW-1:0]      o_sum
);

    logic                          en;
    logic                          r_v1, r_v2, r_v3;
    logic [ppdw_pkg::MagW-1:0]     r_mx, r_my, r_mz;
    logic [ppdw_pkg::SqW-1:0]      r_sx, r_sy, r_sz;
    logic [ppdw_pkg::SumW-1:0]     r_sum;

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_sum   = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx  <= ppdw_pkg::axis_mag(i_item.self_x, i_item.other_x, i_box.box_x);
            r_my  <= ppdw_pkg::axis_mag(i_item.self_y, i_item.other_y, i_box.box_y);
            r_mz  <= ppdw_pkg::axis_mag(i_item.self_z, i_item.other_z, i_box.box_z);
            r_sx  <= 64'(r_mx) * 64'(r_mx);
            r_sy  <= 64'(r_my) * 64'(r_my);
            r_sz  <= 64'(r_mz) * 64'(r_mz);
            r_sum <= 66'(r_sx) + 66'(r_sy) + 66'(r_sz);
        end
    end

endmodule

// ===== src/ppdw_fifo.sv =====
module ppdw_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wptr, r_rptr;
    logic [CntW-1:0]  r_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != Full;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CntW'(do_push) - CntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/ppdw_back.sv =====
module ppdw_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ppdw_pkg::SumW-1:0]      i_sum,
    input  logic [ppdw_pkg::RegW-1:0]      i_cutoff,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ppdw_pkg::t_out_item            o_item
);

    localparam int unsigned SqSt  = ppdw_pkg::RootW;
    localparam int unsigned DivSt = ppdw_pkg::NumW;

    logic en;
    logic r_ov;
    ppdw_pkg::t_out_item r_out;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    logic                          a_v    [SqSt+1];
    logic                          a_ovf  [SqSt+1];
    logic [ppdw_pkg::RemW-1:0]     a_rem  [SqSt+1];
    logic [ppdw_pkg::RootW-1:0]    a_root [SqSt+1];
    logic [ppdw_pkg::SqW-1:0]      a_x    [SqSt+1];

    assign a_v[0]    = i_valid;
    assign a_ovf[0]  = i_sum[ppdw_pkg::SumW-1:ppdw_pkg::SqW] != '0;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_x[0]    = i_sum[ppdw_pkg::SqW-1:0];

    for (genvar g = 0; g < SqSt; g++) begin : g_sqrt
        logic [ppdw_pkg::RemW-1:0] rem_sh, trial;
        logic                      ge;
        logic                      r_v, r_ovf;
        logic [ppdw_pkg::RemW-1:0] r_rem;
        logic [ppdw_pkg::RootW-1:0] r_root;
        logic [ppdw_pkg::SqW-1:0]  r_x;

        assign rem_sh = {a_rem[g][ppdw_pkg::RemW-3:0], a_x[g][63:62]};
        assign trial  = {a_root[g], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ovf  <= a_ovf[g];
                r_rem  <= ge ? rem_sh - trial : rem_sh;
                r_root <= {a_root[g][ppdw_pkg::RootW-2:0], ge};
                r_x    <= {a_x[g][61:0], 2'b00};
            end
        end

        assign a_v[g+1]    = r_v;
        assign a_ovf[g+1]  = r_ovf;
        assign a_rem[g+1]  = r_rem;
        assign a_root[g+1] = r_root;
        assign a_x[g+1]    = r_x;
    end

    logic [31:0] s_dist;
    logic        s_far, s_zero;
    assign s_dist = a_ovf[SqSt] ? ppdw_pkg::SAT_MAX : a_root[SqSt];
    assign s_far  = s_dist >= {1'b0, i_cutoff};
    assign s_zero = s_dist == '0;

    logic                          b_v    [DivSt+1];
    logic                          b_sat  [DivSt+1];
    logic                          b_far  [DivSt+1];
    logic                          b_zero [DivSt+1];
    logic [31:0]                   b_dist [DivSt+1];
    logic [ppdw_pkg::DremW-1:0]    b_rem  [DivSt+1];
    logic [ppdw_pkg::NumW-1:0]     b_q    [DivSt+1];
    logic [ppdw_pkg::NumW-1:0]     b_n    [DivSt+1];

    assign b_v[0]    = a_v[SqSt];
    assign b_sat[0]  = a_ovf[SqSt];
    assign b_far[0]  = s_far;
    assign b_zero[0] = s_zero;
    assign b_dist[0] = s_dist;
    assign b_rem[0]  = '0;
    assign b_q[0]    = '0;
    assign b_n[0]    = {i_cutoff, 16'h0000};

    for (genvar g = 0; g < DivSt; g++) begin : g_div
        logic [ppdw_pkg::DremW-1:0] rem_sh, dv;
        logic                       ge;
        logic                       r_v, r_sat, r_far, r_zero;
        logic [31:0]                r_dist;
        logic [ppdw_pkg::DremW-1:0] r_rem;
        logic [ppdw_pkg::NumW-1:0]  r_q, r_n;

        assign rem_sh = {b_rem[g][ppdw_pkg::DremW-2:0], b_n[g][ppdw_pkg::NumW-1]};
        assign dv     = {1'b0, b_dist[g]};
        assign ge     = rem_sh >= dv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= b_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sat  <= b_sat[g];
                r_far  <= b_far[g];
                r_zero <= b_zero[g];
                r_dist <= b_dist[g];
                r_rem  <= ge ? rem_sh - dv : rem_sh;
                r_q    <= {b_q[g][ppdw_pkg::NumW-2:0], ge};
                r_n    <= {b_n[g][ppdw_pkg::NumW-2:0], 1'b0};
            end
        end

        assign b_v[g+1]    = r_v;
        assign b_sat[g+1]  = r_sat;
        assign b_far[g+1]  = r_far;
        assign b_zero[g+1] = r_zero;
        assign b_dist[g+1] = r_dist;
        assign b_rem[g+1]  = r_rem;
        assign b_q[g+1]    = r_q;
        assign b_n[g+1]    = r_n;
    end

    logic [ppdw_pkg::NumW-1:0] qm;
    ppdw_pkg::t_out_item       n_out;
    assign qm = b_q[DivSt] - ppdw_pkg::Q_ONE;

    always_comb begin
        n_out.distance  = b_dist[DivSt];
        n_out.saturated = b_sat[DivSt];
        priority if (b_far[DivSt]) begin
            n_out.weight = '0;
        end else if (b_zero[DivSt]) begin
            n_out.weight    = ppdw_pkg::SAT_MAX;
            n_out.saturated = 1'b1;
        end else if (qm[ppdw_pkg::NumW-1:32] != '0) begin
            n_out.weight    = ppdw_pkg::SAT_MAX;
            n_out.saturated = 1'b1;
        end else begin
            n_out.weight = qm[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= b_v[DivSt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/periodic_pair_distance_weight.sv =====
// Throughput: one request per cycle while results are taken; back-pressure on the output stalls the pipes.
// The back end holds the square root (one root bit per stage, 32 stages) and the
// divider (one quotient bit per stage, 47 stages); a small queue parts front and back.
// Reset: synchronous, active low; clears all valid bits and the queue, loads
// box lengths of 1.0 and a cutoff radius of 2.0.
module periodic_pair_distance_weight #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ppdw_in_if.sink                        i_in,
    ppdw_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ppdw_pkg::IdxW-1:0]      i_cfg_idx,
    input  logic [ppdw_pkg::RegW-1:0]      i_cfg_data
);

    ppdw_pkg::t_box_cfg            r_box;
    logic [ppdw_pkg::RegW-1:0]     r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.box_x <= ppdw_pkg::BOX_RESET;
            r_box.box_y <= ppdw_pkg::BOX_RESET;
            r_box.box_z <= ppdw_pkg::BOX_RESET;
            r_cutoff    <= ppdw_pkg::CUTOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppdw_pkg::CFG_BOX_X:  r_box.box_x <= i_cfg_data;
                ppdw_pkg::CFG_BOX_Y:  r_box.box_y <= i_cfg_data;
                ppdw_pkg::CFG_BOX_Z:  r_box.box_z <= i_cfg_data;
                ppdw_pkg::CFG_CUTOFF: r_cutoff    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                          f_valid, f_ready;
    logic [ppdw_pkg::SumW-1:0]     f_sum;
    logic                          q_valid, q_pop;
    logic [ppdw_pkg::SumW-1:0]     q_sum;

    ppdw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .i_box   (r_box),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_sum   (f_sum)
    );

    ppdw_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (ppdw_pkg::SumW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (f_ready),
        .i_data  (f_sum),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_sum)
    );

    ppdw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_pop),
        .i_sum    (q_sum),
        .i_cutoff (r_cutoff),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_item   (o_out.data)
    );

`ifndef SYNTHESIS
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.distance == '0 && o_out.data.weight != '0)
        |-> (o_out.data.weight == ppdw_pkg::SAT_MAX && o_out.data.saturated))
        else $error("zero distance without saturated weight");
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result shown after reset");
    a_far_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.distance == ppdw_pkg::SAT_MAX
         && o_out.data.saturated && o_out.data.weight != '0) |-> 1'b0)
        else $error("weight on clipped distance");
`endif

endmodule

// ===== tb/periodic_pair_distance_weight_test.sv =====
`timescale 1ns / 100ps

module periodic_pair_distance_weight_test;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ppdw_pkg::IdxW-1:0] i_cfg_idx = '0;
    logic [ppdw_pkg::RegW-1:0] i_cfg_data = '0;

    ppdw_in_if  req_ch();
    ppdw_out_if rsp_ch();

    periodic_pair_distance_weight i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (req_ch.sink),
        .o_out     (rsp_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    logic [ppdw_pkg::RegW-1:0] box_len[3];
    logic [ppdw_pkg::RegW-1:0] cutoff;
    ppdw_pkg::t_in_item  pending_reqs[$];
    ppdw_pkg::t_out_item expected_pairs[$];
    int        fail_count = 0;
    int        accepted = 0;
    int        total_sent = 0;
    int        send_wait = 0;
    int        recv_wait = 0;
    bit        driving = 1'b0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic logic [32:0] wrapped_mag(logic signed [31:0] s, logic signed [31:0] o,
                                                logic [ppdw_pkg::RegW-1:0] len);
        logic signed [35:0] d;
        logic signed [35:0] l;
        d = 36'(o) - 36'(s);
        l = $signed({5'b0, len});
        if (2 * d < -l) begin
            d = d + l;
        end else if (2 * d > l) begin
            d = d - l;
        end
        if (d < 0) begin
            d = -d;
        end
        return d[32:0];
    endfunction

    function automatic ppdw_pkg::t_out_item pair_distance_weight(ppdw_pkg::t_in_item it);
        logic [32:0]  m[3];
        logic [67:0]  sum;
        logic [67:0]  root;
        logic [67:0]  rem;
        logic [67:0]  bitv;
        logic [95:0]  q;
        ppdw_pkg::t_out_item r;
        m[0] = wrapped_mag(it.self_x, it.other_x, box_len[0]);
        m[1] = wrapped_mag(it.self_y, it.other_y, box_len[1]);
        m[2] = wrapped_mag(it.self_z, it.other_z, box_len[2]);
        sum = 68'(m[0]) * m[0] + 68'(m[1]) * m[1] + 68'(m[2]) * m[2];
        r.saturated = 1'b0;
        r.weight = '0;
        if (sum >= 68'h1_0000_0000_0000_0000) begin
            r.distance = ppdw_pkg::SAT_MAX;
            r.saturated = 1'b1;
        end else begin
            root = '0;
            rem = sum;
            bitv = 68'd1 << 62;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            r.distance = root[31:0];
        end
        if (r.distance < cutoff) begin
            if (r.distance == 0) begin
                r.weight = ppdw_pkg::SAT_MAX;
                r.saturated = 1'b1;
            end else begin
                q = ((96'(cutoff)) << 16) / r.distance - 96'd65536;
                if (q > 96'hFFFF_FFFF) begin
                    r.weight = ppdw_pkg::SAT_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.weight = q[31:0];
                end
            end
        end
        return r;
    endfunction

    function automatic int draw_wait();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_pairs.push_back(pair_distance_weight(req_ch.data));
                accepted++;
            end
            if (req_ch.valid && !req_ch.ready) begin
            end else if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                req_ch.valid <= 1'b0;
            end else if (driving && pending_reqs.size() > 0) begin
                req_ch.data <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                send_wait <= draw_wait();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        ppdw_pkg::t_out_item want;
        int w;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("unexpected result %h", rsp_ch.data);
                    fail_count++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (rsp_ch.data.distance !== want.distance) begin
                        $error("distance expected %h actual %h", want.distance,
                               rsp_ch.data.distance);
                        fail_count++;
                    end
                    if (rsp_ch.data.weight !== want.weight) begin
                        $error("weight expected %h actual %h", want.weight,
                               rsp_ch.data.weight);
                        fail_count++;
                    end
                    if (rsp_ch.data.saturated !== want.saturated) begin
                        $error("saturated expected %b actual %b", want.saturated,
                               rsp_ch.data.saturated);
                        fail_count++;
                    end
                end
                w = draw_wait();
                recv_wait <= w;
                rsp_ch.ready <= (w == 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                rsp_ch.ready <= (recv_wait == 1);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [ppdw_pkg::IdxW-1:0] idx, logic [ppdw_pkg::RegW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == ppdw_pkg::CFG_BOX_X) box_len[0] = val;
        else if (idx == ppdw_pkg::CFG_BOX_Y) box_len[1] = val;
        else if (idx == ppdw_pkg::CFG_BOX_Z) box_len[2] = val;
        else if (idx == ppdw_pkg::CFG_CUTOFF) cutoff = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase();
        driving = 1'b1;
        wait (pending_reqs.size() == 0 && accepted == total_sent);
        driving = 1'b0;
        wait (expected_pairs.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    task automatic add_req(ppdw_pkg::t_in_item it);
        pending_reqs.push_back(it);
        total_sent++;
    endtask

    task automatic add_random(int n);
        ppdw_pkg::t_in_item it;
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(0, 5);
            it.self_x = coord(mode); it.self_y = coord(mode); it.self_z = coord(mode);
            if ($urandom_range(0, 9) == 0) begin
                it.other_x = it.self_x; it.other_y = it.self_y; it.other_z = it.self_z;
            end else if (mode >= 3) begin
                it.other_x = it.self_x + coord(3);
                it.other_y = it.self_y + coord(3);
                it.other_z = it.self_z + coord(3);
            end else begin
                it.other_x = coord(mode); it.other_y = coord(mode); it.other_z = coord(mode);
            end
            add_req(it);
        end
    endtask

    initial begin
        ppdw_pkg::t_in_item it;
        box_len[0] = ppdw_pkg::BOX_RESET;
        box_len[1] = ppdw_pkg::BOX_RESET;
        box_len[2] = ppdw_pkg::BOX_RESET;
        cutoff = ppdw_pkg::CUTOFF_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        it = '0; add_req(it);
        it.other_x = 32'h0000_8000; add_req(it);
        it.other_x = 32'h0000_8001; add_req(it);
        it.other_x = 32'hFFFF_7FFF; add_req(it);
        it = '0; it.other_y = 32'h0000_0001; add_req(it);
        it = '0; it.self_x = 32'h8000_0000; it.other_x = 32'h7FFF_FFFF; add_req(it);
        it = '0; it.self_z = 32'h7FFF_FFFF; it.other_z = 32'h8000_0000; add_req(it);
        it = '1; add_req(it);
        run_phase();

        write_reg(ppdw_pkg::CFG_BOX_X, 31'h7FFF_FFFF);
        write_reg(ppdw_pkg::CFG_BOX_Y, 31'h7FFF_FFFF);
        write_reg(ppdw_pkg::CFG_BOX_Z, 31'h7FFF_FFFF);
        write_reg(ppdw_pkg::CFG_CUTOFF, 31'h7FFF_FFFF);
        it = '0; it.self_x = 32'h8000_0000; it.other_x = 32'h7FFF_FFFF;
        it.self_y = 32'h8000_0000; it.other_y = 32'h7FFF_FFFF;
        it.self_z = 32'h7FFF_FFFF; it.other_z = 32'h8000_0000; add_req(it);
        it = '0; it.other_x = 32'h0000_0001; add_req(it);
        it = '0; add_req(it);
        add_random(200);
        run_phase();

        write_reg(ppdw_pkg::CFG_BOX_X, 31'd1);
        write_reg(ppdw_pkg::CFG_BOX_Y, 31'd1);
        write_reg(ppdw_pkg::CFG_BOX_Z, 31'd1);
        write_reg(ppdw_pkg::CFG_CUTOFF, 31'd1);
        add_random(150);
        run_phase();

        write_reg(ppdw_pkg::CFG_BOX_X, 31'h0003_0000);
        write_reg(ppdw_pkg::CFG_BOX_Y, 31'h0002_8000);
        write_reg(ppdw_pkg::CFG_BOX_Z, 31'h0004_0000);
        write_reg(ppdw_pkg::CFG_CUTOFF, 31'h0001_8000);
        add_random(250);
        run_phase();

        write_reg(ppdw_pkg::CFG_BOX_X, 31'($urandom_range(1, 32'h7FFF_FFFF)));
        write_reg(ppdw_pkg::CFG_BOX_Y, 31'($urandom_range(1, 32'h0010_0000)));
        write_reg(ppdw_pkg::CFG_BOX_Z, 31'($urandom_range(1, 32'h0010_0000)));
        write_reg(ppdw_pkg::CFG_CUTOFF, 31'($urandom_range(1, 32'h7FFF_FFFF)));
        write_reg(3'd5, 31'd7);
        add_random(200);
        run_phase();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end
endmodule
